### sv/sttmr_pkg.sv
// ============================================================================
// sttmr_pkg - shared constants for the trapezoidal step timer
// Phase codes, register indexes and default widths.
// ============================================================================
package sttmr_pkg;

    localparam int STEP_BITS_DEF  = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int TICK_BITS      = 32;
    localparam int PHASE_BITS     = 2;
    localparam int CFG_INDEX_BITS = 4;

    // profile phase codes
    localparam logic [PHASE_BITS-1:0] PH_ACCEL  = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_CRUISE = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_DECEL  = 2'd2;
    localparam logic [PHASE_BITS-1:0] PH_DONE   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_STEPS     = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACCEL_STEPS     = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CRUISE_STEPS    = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACCEL_FACTOR    = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TICKS_PER_STEP  = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACCEL_END_TICKS = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MOVE_TICKS      = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_TICK      = 4'd7;

endpackage

### sv/stepper_trapezoid_step_timer.sv
// ============================================================================
// stepper_trapezoid_step_timer - trapezoidal profile step timing
// Maps a step number of a move to its absolute fire tick and profile phase.
// ============================================================================
// Usage
//   Software loads the move set-up through the write port (cfg_wr_en,
//   cfg_wr_index, cfg_wr_data) while the block is idle. Step requests enter
//   on s_valid/s_ready with s_step_index; each request gives one result on
//   m_valid/m_ready carrying m_fire_tick and m_phase (0 accel, 1 cruise,
//   2 decel, 3 done).
// Throughput and stages
//   One request per cycle while the receiver keeps taking results. SQS is
//   the number of square root stages, two root bits per stage. Stages:
//   phase decode, radicand set-up, SQS root stages, shared multiplier,
//   offset/saturation, then the output queue.
// Stalls and reset
//   The pipeline never stops; a credit counter bounds requests in flight to
//   the depth of the output queue, so a stalled receiver only fills the
//   queue and then drops s_ready. Nothing is lost or repeated.
//   aresetn (synchronous, low) clears the set-up registers to zero, empties
//   the pipeline and the queue.
// ============================================================================
module stepper_trapezoid_step_timer
    import sttmr_pkg::*;
#(
    parameter int STEP_BITS = STEP_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_wr_index,
    input  logic [TICK_BITS-1:0]      cfg_wr_data,
    // step request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [STEP_BITS-1:0]      s_step_index,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [TICK_BITS-1:0]      m_fire_tick,
    output logic [PHASE_BITS-1:0]     m_phase
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    // root of (n << 2*FRAC) needs RW bits; padded to an even RB for 2 bits/stage
    localparam int RW  = (STEP_BITS + 1) / 2 + FRAC_BITS;
    localparam int SQS = (RW + 1) / 2;
    localparam int RB  = 2 * SQS;
    localparam int NW  = 2 * RB;
    // multiplier operand A is either the root or the cruise step delta
    localparam int AW  = (RB > STEP_BITS) ? RB : STEP_BITS;
    localparam int PW  = AW + TICK_BITS;
    localparam int OW  = PW + 1;
    // output queue depth covers every request that can be in flight
    localparam int FD   = SQS + 6;
    localparam int PTRW = $clog2(FD);
    localparam int CNTW = $clog2(FD + 1);

    typedef struct packed {
        logic [NW-1:0] rad;
        logic [RB+1:0] rem;
        logic [RB-1:0] q;
    } sq_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [TICK_BITS-1:0]  fire;
    } out_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STEP_BITS-1:0] total_steps_reg;
    logic [STEP_BITS-1:0] accel_steps_reg;
    logic [STEP_BITS-1:0] cruise_steps_reg;
    logic [TICK_BITS-1:0] accel_factor_reg;
    logic [TICK_BITS-1:0] ticks_per_step_reg;
    logic [TICK_BITS-1:0] accel_end_ticks_reg;
    logic [TICK_BITS-1:0] move_ticks_reg;
    logic [TICK_BITS-1:0] start_tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_steps_reg     <= '0;
            accel_steps_reg     <= '0;
            cruise_steps_reg    <= '0;
            accel_factor_reg    <= '0;
            ticks_per_step_reg  <= '0;
            accel_end_ticks_reg <= '0;
            move_ticks_reg      <= '0;
            start_tick_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_TOTAL_STEPS:     total_steps_reg     <= cfg_wr_data[STEP_BITS-1:0];
                REG_ACCEL_STEPS:     accel_steps_reg     <= cfg_wr_data[STEP_BITS-1:0];
                REG_CRUISE_STEPS:    cruise_steps_reg    <= cfg_wr_data[STEP_BITS-1:0];
                REG_ACCEL_FACTOR:    accel_factor_reg    <= cfg_wr_data;
                REG_TICKS_PER_STEP:  ticks_per_step_reg  <= cfg_wr_data;
                REG_ACCEL_END_TICKS: accel_end_ticks_reg <= cfg_wr_data;
                REG_MOVE_TICKS:      move_ticks_reg      <= cfg_wr_data;
                REG_START_TICK:      start_tick_reg      <= cfg_wr_data;
                default: ; // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Credit counter: requests accepted and not yet delivered
    // ------------------------------------------------------------------
    logic            s_accept;
    logic            m_accept;
    logic [CNTW-1:0] credit_reg;
    logic [CNTW-1:0] credit_next;

    assign s_ready  = (credit_reg != CNTW'(FD));
    assign s_accept = s_valid && s_ready;
    assign m_accept = m_valid && m_ready;

    always_comb begin
        credit_next = credit_reg;
        if (s_accept && !m_accept) begin
            credit_next = credit_reg + CNTW'(1);
        end else if (!s_accept && m_accept) begin
            credit_next = credit_reg - CNTW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: phase decode
    // ------------------------------------------------------------------
    logic                  p0_valid_reg;
    logic [STEP_BITS-1:0]  p0_step_reg;
    logic [PHASE_BITS-1:0] p0_phase_reg;
    logic [PHASE_BITS-1:0] p0_phase_next;
    logic [STEP_BITS:0]    plateau_end;

    always_comb begin
        // accel + cruise formed one bit wider, no wrap
        plateau_end = {1'b0, accel_steps_reg} + {1'b0, cruise_steps_reg};
        if (s_step_index <= accel_steps_reg) begin
            p0_phase_next = PH_ACCEL;
        end else if (s_step_index >= total_steps_reg) begin
            p0_phase_next = PH_DONE;
        end else if ({1'b0, s_step_index} > plateau_end) begin
            p0_phase_next = PH_DECEL;
        end else begin
            p0_phase_next = PH_CRUISE;
        end
    end

    // ------------------------------------------------------------------
    // Square root pipeline: stage 0 is radicand set-up, then SQS stages
    // of two restoring root bits each
    // ------------------------------------------------------------------
    logic [SQS:0]          sq_valid_reg;
    sq_t                   sq_reg      [0:SQS];
    sq_t                   sq_next     [0:SQS];
    logic [PHASE_BITS-1:0] sq_phase_reg[0:SQS];
    logic [STEP_BITS-1:0]  sq_delta_reg[0:SQS];
    logic [STEP_BITS-1:0]  radicand;

    function automatic sq_t sqrt_step(input sq_t cur);
        sq_t           nxt;
        logic [RB+1:0] rem2;
        logic [RB+1:0] trial;
        nxt = cur;
        for (int k = 0; k < 2; k++) begin
            rem2    = {nxt.rem[RB-1:0], nxt.rad[NW-1 -: 2]};
            trial   = {nxt.q, 2'b01};
            nxt.rad = {nxt.rad[NW-3:0], 2'b00};
            if (rem2 >= trial) begin
                nxt.rem = rem2 - trial;
                nxt.q   = {nxt.q[RB-2:0], 1'b1};
            end else begin
                nxt.rem = rem2;
                nxt.q   = {nxt.q[RB-2:0], 1'b0};
            end
        end
        return nxt;
    endfunction

    always_comb begin
        // distance to the end during decel, else the step itself
        radicand = (p0_phase_reg == PH_DECEL) ? total_steps_reg - p0_step_reg
                                              : p0_step_reg;
        sq_next[0].rad = NW'(radicand) << (2 * FRAC_BITS);
        sq_next[0].rem = '0;
        sq_next[0].q   = '0;
        for (int i = 1; i <= SQS; i++) begin
            sq_next[i] = sqrt_step(sq_reg[i-1]);
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: root * accel_factor or delta * ticks_per_step
    // ------------------------------------------------------------------
    logic                  pm_valid_reg;
    logic [PHASE_BITS-1:0] pm_phase_reg;
    logic [PW-1:0]         pm_prod_reg;
    logic [AW-1:0]         mul_a;
    logic [TICK_BITS-1:0]  mul_b;

    always_comb begin
        if (sq_phase_reg[SQS] == PH_CRUISE) begin
            mul_a = AW'(sq_delta_reg[SQS]);
            mul_b = ticks_per_step_reg;
        end else begin
            mul_a = AW'(sq_reg[SQS].q);
            mul_b = accel_factor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Offset stage: rounding, saturation, phase select
    // ------------------------------------------------------------------
    logic                  po_valid_reg;
    logic [PHASE_BITS-1:0] po_phase_reg;
    logic [TICK_BITS-1:0]  po_offset_reg;
    logic [TICK_BITS-1:0]  po_offset_next;
    logic [OW-1:0]         root_whole;
    logic [OW-1:0]         root_up;
    logic [OW-1:0]         cruise_sum;

    function automatic logic [TICK_BITS-1:0] sat32(input logic [OW-1:0] v);
        logic [OW-1:0] lim;
        lim = OW'({TICK_BITS{1'b1}});
        return (v > lim) ? {TICK_BITS{1'b1}} : v[TICK_BITS-1:0];
    endfunction

    always_comb begin
        root_whole = OW'(pm_prod_reg >> (2 * FRAC_BITS));
        // decel rounds the root term up so the floor lands on the difference
        root_up    = root_whole + OW'(|pm_prod_reg[2*FRAC_BITS-1:0]);
        cruise_sum = OW'(pm_prod_reg >> FRAC_BITS) + OW'(accel_end_ticks_reg);
        case (pm_phase_reg)
            PH_ACCEL:  po_offset_next = sat32(root_whole);
            PH_CRUISE: po_offset_next = sat32(cruise_sum);
            PH_DECEL: begin
                if (OW'(move_ticks_reg) >= root_up) begin
                    po_offset_next = move_ticks_reg - root_up[TICK_BITS-1:0];
                end else begin
                    po_offset_next = '0;
                end
            end
            default:   po_offset_next = move_ticks_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline registers; every stage advances each cycle
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            sq_valid_reg <= '0;
            pm_valid_reg <= 1'b0;
            po_valid_reg <= 1'b0;
        end else begin
            p0_valid_reg <= s_accept;
            sq_valid_reg <= {sq_valid_reg[SQS-1:0], p0_valid_reg};
            pm_valid_reg <= sq_valid_reg[SQS];
            po_valid_reg <= pm_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p0_step_reg     <= s_step_index;
        p0_phase_reg    <= p0_phase_next;
        sq_reg[0]       <= sq_next[0];
        sq_phase_reg[0] <= p0_phase_reg;
        sq_delta_reg[0] <= p0_step_reg - accel_steps_reg;
        for (int i = 1; i <= SQS; i++) begin
            sq_reg[i]       <= sq_next[i];
            sq_phase_reg[i] <= sq_phase_reg[i-1];
            sq_delta_reg[i] <= sq_delta_reg[i-1];
        end
        pm_phase_reg  <= sq_phase_reg[SQS];
        pm_prod_reg   <= PW'(mul_a) * PW'(mul_b);
        po_phase_reg  <= pm_phase_reg;
        po_offset_reg <= po_offset_next;
    end

    // ------------------------------------------------------------------
    // Output queue; start tick added with 32-bit wrap on the way in
    // ------------------------------------------------------------------
    out_t            fifo_mem_reg [0:FD-1];
    out_t            fifo_wr_data;
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW-1:0] rd_ptr_next;
    logic [CNTW-1:0] fill_reg;
    logic [CNTW-1:0] fill_next;

    always_comb begin
        fifo_wr_data.phase = po_phase_reg;
        fifo_wr_data.fire  = po_offset_reg + start_tick_reg;
        wr_ptr_next = wr_ptr_reg;
        if (po_valid_reg) begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(FD - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        rd_ptr_next = rd_ptr_reg;
        if (m_accept) begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(FD - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        fill_next = fill_reg;
        if (po_valid_reg && !m_accept) begin
            fill_next = fill_reg + CNTW'(1);
        end else if (!po_valid_reg && m_accept) begin
            fill_next = fill_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (po_valid_reg) begin
            fifo_mem_reg[wr_ptr_reg] <= fifo_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

    assign m_valid     = (fill_reg != '0);
    assign m_fire_tick = fifo_mem_reg[rd_ptr_reg].fire;
    assign m_phase     = fifo_mem_reg[rd_ptr_reg].phase;

endmodule

### bench/tb_stepper_trapezoid_step_timer.sv
// ============================================================================
// tb_stepper_trapezoid_step_timer - self-checking bench for the step timer
// Loads move profiles through the write port and sends step requests. Each
// request is run through a local timing predictor, and every result is
// compared in order against the oldest predicted timing. Both channels idle
// at random, with one stretch that has no idling at all.
// ============================================================================
module tb_stepper_trapezoid_step_timer;
    import sttmr_pkg::*;

    localparam int SB          = STEP_BITS_DEF;
    localparam int FB          = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    // more than the accept-to-result latency of the block
    localparam int SETTLE_CYCLES = 24;
    localparam logic [SB-1:0]        STEP_MAX = '1;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic [TICK_BITS-1:0]  fire_tick;
        logic [PHASE_BITS-1:0] phase;
    } step_timing_t;

    // how a random move profile is drawn
    typedef enum int {
        PROF_SANE,
        PROF_WILD,
        PROF_EDGES
    } profile_kind_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                      aclk         = 1'b0;
    logic                      aresetn      = 1'b0;
    logic                      cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_wr_index = '0;
    logic [TICK_BITS-1:0]      cfg_wr_data  = '0;
    logic                      s_valid      = 1'b0;
    logic                      s_ready;
    logic [SB-1:0]             s_step_index = '0;
    logic                      m_valid;
    logic                      m_ready      = 1'b0;
    logic [TICK_BITS-1:0]      m_fire_tick;
    logic [PHASE_BITS-1:0]     m_phase;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    step_timing_t pending_timings[$];   // predicted timings, oldest first
    int           errors     = 0;
    int           cycles     = 0;
    bit           steady     = 1'b0;    // no idling on either side while set

    // shadow copy of the move set-up
    logic [SB-1:0]        prof_total_steps;
    logic [SB-1:0]        prof_accel_steps;
    logic [SB-1:0]        prof_cruise_steps;
    logic [TICK_BITS-1:0] prof_accel_factor;
    logic [TICK_BITS-1:0] prof_ticks_per_step;
    logic [TICK_BITS-1:0] prof_accel_end_ticks;
    logic [TICK_BITS-1:0] prof_move_ticks;
    logic [TICK_BITS-1:0] prof_start_tick;

    stepper_trapezoid_step_timer uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_step_index (s_step_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fire_tick  (m_fire_tick),
        .m_phase      (m_phase)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // timing predictor
    // ------------------------------------------------------------------------
    // bit-serial integer square root, floor
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] rem;
        root  = '0;
        rem   = n;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // sqrt(n) * accel_factor, exact, 2*FB fractional bits
    function automatic logic [63:0] root_product(input logic [SB-1:0] n);
        logic [63:0] radicand;
        logic [63:0] root;
        radicand = 64'(n) << (2 * FB);
        root     = isqrt64(radicand);
        return root * 64'(prof_accel_factor);
    endfunction

    function automatic logic [TICK_BITS-1:0] clamp_ticks(input logic [63:0] v);
        return (v > 64'(TICK_MAX)) ? TICK_MAX : v[TICK_BITS-1:0];
    endfunction

    function automatic step_timing_t predict_timing(input logic [SB-1:0] step);
        step_timing_t         t;
        logic [63:0]          prod;
        logic [63:0]          up;
        logic [63:0]          diff;
        logic [63:0]          lin;
        logic [TICK_BITS-1:0] offset;
        logic [SB:0]          plateau_end;
        plateau_end = {1'b0, prof_accel_steps} + {1'b0, prof_cruise_steps};
        if (step <= prof_accel_steps) begin
            // accel wins even past the total step count
            t.phase = PH_ACCEL;
            prod    = root_product(step);
            offset  = clamp_ticks(prod >> (2 * FB));
        end else if (step >= prof_total_steps) begin
            t.phase = PH_DONE;
            offset  = prof_move_ticks;
        end else if ({1'b0, step} > plateau_end) begin
            // root term rounds up, offset floors at zero
            t.phase = PH_DECEL;
            prod    = root_product(prof_total_steps - step);
            up      = prod >> (2 * FB);
            if ((prod & ((64'd1 << (2 * FB)) - 1)) != 0)
                up = up + 1;
            offset  = (64'(prof_move_ticks) >= up) ? prof_move_ticks - up[TICK_BITS-1:0]
                                                   : '0;
        end else begin
            t.phase = PH_CRUISE;
            diff    = step - prof_accel_steps;
            lin     = diff * 64'(prof_ticks_per_step);
            lin     = lin >> FB;
            offset  = clamp_ticks(lin + 64'(prof_accel_end_ticks));
        end
        t.fire_tick = offset + prof_start_tick;   // 32-bit wrap
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [TICK_BITS-1:0] got,
                                   input logic [TICK_BITS-1:0] want);
        if (errors < 100)
            $display("MISMATCH cycle %0d: %s got 0x%08h want 0x%08h",
                     cycles, what, got, want);
        errors++;
    endtask

    // one register write, shadow updated alongside (block is idle here)
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [TICK_BITS-1:0] data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        case (idx)
            REG_TOTAL_STEPS:     prof_total_steps     = data[SB-1:0];
            REG_ACCEL_STEPS:     prof_accel_steps     = data[SB-1:0];
            REG_CRUISE_STEPS:    prof_cruise_steps    = data[SB-1:0];
            REG_ACCEL_FACTOR:    prof_accel_factor    = data;
            REG_TICKS_PER_STEP:  prof_ticks_per_step  = data;
            REG_ACCEL_END_TICKS: prof_accel_end_ticks = data;
            REG_MOVE_TICKS:      prof_move_ticks      = data;
            REG_START_TICK:      prof_start_tick      = data;
            default: ;           // unknown index, ignored by the block
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_profile(input logic [SB-1:0] total, input logic [SB-1:0] accel,
                                input logic [SB-1:0] cruise,
                                input logic [TICK_BITS-1:0] factor,
                                input logic [TICK_BITS-1:0] per_step,
                                input logic [TICK_BITS-1:0] accel_end,
                                input logic [TICK_BITS-1:0] move_len,
                                input logic [TICK_BITS-1:0] start);
        write_reg(REG_TOTAL_STEPS,     TICK_BITS'(total));
        write_reg(REG_ACCEL_STEPS,     TICK_BITS'(accel));
        write_reg(REG_CRUISE_STEPS,    TICK_BITS'(cruise));
        write_reg(REG_ACCEL_FACTOR,    factor);
        write_reg(REG_TICKS_PER_STEP,  per_step);
        write_reg(REG_ACCEL_END_TICKS, accel_end);
        write_reg(REG_MOVE_TICKS,      move_len);
        write_reg(REG_START_TICK,      start);
    endtask

    // send one step request; valid stays high afterwards until the next
    // negedge decides whether to idle or to present the next request
    task automatic send_step(input logic [SB-1:0] step);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 30)
            gap = $urandom_range(3, 1);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_step_index <= step;
        do @(posedge aclk); while (!s_ready);
        pending_timings.push_back(predict_timing(step));
    endtask

    // drop valid and hold off until every predicted timing has arrived
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_timings.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random back-pressure and the in-order checker
    // ------------------------------------------------------------------------
    always @(negedge aclk)
        m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 38);

    always @(posedge aclk) begin : check_results
        step_timing_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_timings.size() == 0) begin
                report_mismatch("result with no request pending", m_fire_tick, '0);
            end else begin
                want = pending_timings.pop_front();
                if (m_fire_tick !== want.fire_tick)
                    report_mismatch("fire_tick", m_fire_tick, want.fire_tick);
                if (m_phase !== want.phase)
                    report_mismatch("phase", TICK_BITS'(m_phase), TICK_BITS'(want.phase));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("stepper_trapezoid_step_timer test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // all registers zero: step 0 is accel with offset 0, anything else done
    task automatic test_reset_defaults();
        prof_total_steps     = '0;
        prof_accel_steps     = '0;
        prof_cruise_steps    = '0;
        prof_accel_factor    = '0;
        prof_ticks_per_step  = '0;
        prof_accel_end_ticks = '0;
        prof_move_ticks      = '0;
        prof_start_tick      = '0;
        send_step('0);
        send_step(SB'(1));
        send_step(STEP_MAX);
        wait_for_results();
    endtask

    // an ordinary move, walking across every phase boundary
    task automatic test_profile_phases();
        load_profile(SB'(1000), SB'(100), SB'(800), 32'h0000_1A80, 32'h0000_0380,
                     32'd5000, 32'd12000, 32'h0001_0000);
        send_step('0);
        send_step(SB'(1));
        send_step(SB'(99));
        send_step(SB'(100));
        send_step(SB'(101));
        send_step(SB'(500));
        send_step(SB'(900));
        send_step(SB'(901));
        send_step(SB'(999));
        send_step(SB'(1000));
        send_step(STEP_MAX);
        wait_for_results();
    endtask

    // saturation, wrap, underflow and phase-order corners
    task automatic test_arith_limits();
        // accel offset saturates, start_tick wraps it; phase sum must not wrap
        load_profile(STEP_MAX, STEP_MAX, STEP_MAX, TICK_MAX, TICK_MAX,
                     TICK_MAX, TICK_MAX, TICK_MAX);
        send_step(STEP_MAX);
        send_step('0);
        wait_for_results();
        // cruise offset saturates
        load_profile(STEP_MAX, '0, STEP_MAX - 15, '0, TICK_MAX, TICK_MAX, '0, 32'd1);
        send_step(STEP_MAX - 15);
        send_step(STEP_MAX - 1);    // decel with a zero factor
        wait_for_results();
        // decel root term larger than move_ticks floors at zero
        load_profile(STEP_MAX, '0, '0, TICK_MAX, '0, '0, 32'd100, 32'h8000_0000);
        send_step(SB'(1));
        send_step(STEP_MAX - 1);
        wait_for_results();
        // accel range reaching past the total step count
        load_profile(SB'(10), SB'(50), '0, 32'h0000_0100, 32'h0000_0100,
                     32'd7, 32'd900, 32'd3);
        send_step(SB'(30));
        send_step(SB'(51));
        wait_for_results();
    endtask

    // upper bits of step registers are dropped, unknown indexes are ignored
    task automatic test_register_masking();
        write_reg(REG_TOTAL_STEPS,  32'hA500_0400);
        write_reg(REG_ACCEL_STEPS,  32'h5A00_0040);
        write_reg(REG_CRUISE_STEPS, 32'hFF00_0100);
        for (int i = int'(REG_START_TICK) + 1; i < (1 << CFG_INDEX_BITS); i++)
            write_reg(CFG_INDEX_BITS'(i), $urandom);
        send_step(SB'(64));
        send_step(SB'(200));
        send_step(SB'(1000));
        wait_for_results();
    endtask

    task automatic load_random_profile(input profile_kind_t kind);
        logic [SB-1:0] total;
        logic [SB-1:0] accel;
        logic [SB-1:0] cruise;
        int            t;
        int            a;
        case (kind)
            PROF_SANE: begin
                t = $urandom_range(4000, 1);
                a = $urandom_range(t, 0);
                load_profile(SB'(t), SB'(a), SB'($urandom_range(t - a, 0)),
                             $urandom_range(32'h0010_0000, 0),
                             $urandom_range(32'h0001_0000, 0),
                             $urandom, $urandom, $urandom);
            end
            PROF_WILD: begin
                total  = SB'($urandom);
                accel  = SB'($urandom_range(32'(total), 0));
                cruise = SB'($urandom);
                load_profile(total, accel, cruise, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
            end
            default: begin
                load_profile($urandom_range(1) ? STEP_MAX : '0,
                             $urandom_range(1) ? STEP_MAX : '0,
                             $urandom_range(1) ? STEP_MAX : '0,
                             $urandom_range(1) ? TICK_MAX : '0,
                             $urandom_range(1) ? TICK_MAX : '0,
                             $urandom_range(1) ? TICK_MAX : '0,
                             $urandom_range(1) ? TICK_MAX : '0,
                             $urandom_range(1) ? TICK_MAX : '0);
            end
        endcase
    endtask

    // mostly steps inside the move, some on the boundaries, some anywhere
    function automatic logic [SB-1:0] pick_step();
        int unsigned r;
        int unsigned s;
        r = $urandom_range(99);
        if (r < 60) begin
            s = $urandom_range(32'(prof_total_steps) + 2, 0);
        end else if (r < 80) begin
            case ($urandom_range(5))
                0:       s = 32'(prof_accel_steps);
                1:       s = 32'(prof_accel_steps) + 1;
                2:       s = 32'(prof_accel_steps) + 32'(prof_cruise_steps);
                3:       s = 32'(prof_accel_steps) + 32'(prof_cruise_steps) + 1;
                4:       s = 32'(prof_total_steps) - 1;
                default: s = 32'(prof_total_steps);
            endcase
        end else begin
            s = $urandom;
        end
        return s[SB-1:0];
    endfunction

    task automatic test_random_profiles();
        profile_kind_t kind;
        int unsigned   r;
        for (int ph = 0; ph < 16; ph++) begin
            r    = $urandom_range(9);
            kind = (r < 6) ? PROF_SANE : (r < 8) ? PROF_WILD : PROF_EDGES;
            load_random_profile(kind);
            steady = (ph == 5);     // one long back-to-back burst
            repeat (100) send_step(pick_step());
            wait_for_results();
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_profile_phases();
        test_arith_limits();
        test_register_masking();
        test_random_profiles();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_timings.size() == 0) begin
            $display("stepper_trapezoid_step_timer test passed");
        end else begin
            $display("stepper_trapezoid_step_timer test failed");
        end
        $finish;
    end

endmodule
